@@ rtl/stbl_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted table engine package
// Shared transaction types, request and status codes, and the cell command
// type used between the top level and the cell chain.
// ----------------------------------------------------------------------------
package stbl_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;

    // Request codes.
    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_POP    = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Cell commands.
    localparam logic [2:0] CELL_HOLD  = 3'd0;
    localparam logic [2:0] CELL_CMP   = 3'd1;
    localparam logic [2:0] CELL_WRPAY = 3'd2;
    localparam logic [2:0] CELL_INS   = 3'd3;
    localparam logic [2:0] CELL_DEL   = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] payload;
    } stbl_in_t;

    typedef struct packed {
        logic        found;
        logic [8:0]  index;
        logic [31:0] out_key;
        logic [31:0] out_payload;
        logic [1:0]  status;
        logic [8:0]  entry_count;
    } stbl_out_t;

    typedef struct packed {
        logic [2:0] op;
        logic       hit;
        logic       above;
    } stbl_cell_ctrl_t;

endpackage

@@ rtl/stbl_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry, compares it against the broadcast key and moves
// entries to or from its neighbors when the table opens or closes a gap.
// ----------------------------------------------------------------------------
module stbl_cell #(
    parameter int KEY_BITS = stbl_pkg::KEY_BITS_DEF
) (
    input  logic                      aclk,
    input  stbl_pkg::stbl_cell_ctrl_t ctrl,
    input  logic                      desc,
    input  logic [KEY_BITS-1:0]       cmp_key,
    input  logic [KEY_BITS-1:0]       new_key,
    input  logic [31:0]               new_pay,
    input  logic [KEY_BITS-1:0]       prev_key,
    input  logic [31:0]               prev_pay,
    input  logic [KEY_BITS-1:0]       next_key,
    input  logic [31:0]               next_pay,
    output logic [KEY_BITS-1:0]       key_q,
    output logic [31:0]               pay_q,
    output logic                      key_lt,
    output logic                      ent_lt
);
    import stbl_pkg::*;

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [31:0]         pay_reg, pay_next;
    logic                klt_reg, klt_next;
    logic                elt_reg, elt_next;

    always_comb begin
        key_next = key_reg;
        pay_next = pay_reg;
        klt_next = klt_reg;
        elt_next = elt_reg;
        unique case (ctrl.op)
            CELL_CMP: begin
                // The order test flips with the direction setting.
                klt_next = desc ? (key_reg < cmp_key) : (cmp_key < key_reg);
                elt_next = desc ? (cmp_key < key_reg) : (key_reg < cmp_key);
            end
            CELL_WRPAY: begin
                if (ctrl.hit) begin
                    pay_next = new_pay;
                end
            end
            CELL_INS: begin
                if (ctrl.above) begin
                    key_next = prev_key;
                    pay_next = prev_pay;
                end else if (ctrl.hit) begin
                    key_next = new_key;
                    pay_next = new_pay;
                end
            end
            CELL_DEL: begin
                if (ctrl.above || ctrl.hit) begin
                    key_next = next_key;
                    pay_next = next_pay;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pay_reg <= pay_next;
        klt_reg <= klt_next;
        elt_reg <= elt_next;
    end

    assign key_q  = key_reg;
    assign pay_q  = pay_reg;
    assign key_lt = klt_reg;
    assign ent_lt = elt_reg;

endmodule

@@ rtl/sorted_table_engine.sv @@
// ----------------------------------------------------------------------------
// Sorted table engine
// Keyed table kept in order in a chain of entry cells, with search, insert,
// delete and pop requests.
// ----------------------------------------------------------------------------
// Usage: a request transaction on the s_ channel carries a mode, a key and a
// payload. Exactly one result transaction leaves on the m_ channel for each
// request. The block takes one request at a time: s_ready is high only while
// no request is in progress.
// Timing: the accepting edge loads the key into every cell, which compares
// it against its entry in parallel. A binary search then walks over the
// registered compare bits, one probe per cycle. The update state then
// applies the update to the cells, where all entries shift together, and
// writes the result register. A new request can be accepted the cycle
// after the result is written.
// Stalls: the result register holds while m_ready is low; the next request
// may be accepted and searched meanwhile, and waits before its update.
// Reset: the entry count and the order setting clear; entry contents are
// left as they are and are never read before being written.
// The order setting (cfg_we, cfg_wdata) may only be written while idle.
// ----------------------------------------------------------------------------
module sorted_table_engine #(
    parameter int CAPACITY = stbl_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = stbl_pkg::KEY_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stbl_pkg::stbl_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stbl_pkg::stbl_out_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);
    import stbl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SRCH = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                desc_reg;
    logic                m_valid_reg, m_valid_next;
    stbl_out_t           m_data_reg, m_data_next;

    // Request held for the duration of the transaction.
    logic [1:0]          mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [31:0]         pay_reg, pay_next;

    // Binary search bounds and outcome.
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [CNT_W-1:0]    mid;
    logic [IDX_W-1:0]    mid_sel;

    logic [KEY_BITS+31:0] key_in_wide;
    logic [KEY_BITS-1:0]  key_in;

    // Cell chain wiring.
    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [31:0]         cell_pay [CAPACITY];
    logic [CAPACITY-1:0] key_lt_vec;
    logic [CAPACITY-1:0] ent_lt_vec;
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] above_vec;
    logic [2:0]          cell_op;

    logic [KEY_BITS-1:0] sel_key;
    logic [31:0]         sel_pay;
    logic [KEY_BITS+31:0] sel_key_wide;
    logic [CNT_W+8:0]    idx_wide;
    logic [CNT_W+8:0]    cnt_wide;

    logic                act_fire;
    logic                res_found;
    logic [CNT_W-1:0]    res_idx;
    logic [31:0]         res_key;
    logic [31:0]         res_pay;
    logic [1:0]          res_status;
    logic [2:0]          act_op;

    assign key_in_wide = {{KEY_BITS{1'b0}}, s_data.key};
    assign key_in      = key_in_wide[KEY_BITS-1:0];

    assign s_ready  = (state_reg == ST_IDLE);
    assign act_fire = (state_reg == ST_ACT) && (!m_valid_reg || m_ready);

    // The chain: cell i takes from cell i-1 when the table opens a gap and
    // from cell i+1 when it closes one.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        stbl_cell_ctrl_t     ctrl;
        logic [KEY_BITS-1:0] prev_key, next_key;
        logic [31:0]         prev_pay, next_pay;

        assign hit_vec[i]   = (CNT_W'(i) == idx_reg);
        assign above_vec[i] = (CNT_W'(i) > idx_reg);
        assign ctrl.op      = cell_op;
        assign ctrl.hit     = hit_vec[i];
        assign ctrl.above   = above_vec[i];

        if (i == 0) begin : g_first
            assign prev_key = '0;
            assign prev_pay = '0;
        end else begin : g_mid_prev
            assign prev_key = cell_key[i-1];
            assign prev_pay = cell_pay[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_key = '0;
            assign next_pay = '0;
        end else begin : g_mid_next
            assign next_key = cell_key[i+1];
            assign next_pay = cell_pay[i+1];
        end

        stbl_cell #(
            .KEY_BITS(KEY_BITS)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .desc    (desc_reg),
            .cmp_key (key_in),
            .new_key (key_reg),
            .new_pay (pay_reg),
            .prev_key(prev_key),
            .prev_pay(prev_pay),
            .next_key(next_key),
            .next_pay(next_pay),
            .key_q   (cell_key[i]),
            .pay_q   (cell_pay[i]),
            .key_lt  (key_lt_vec[i]),
            .ent_lt  (ent_lt_vec[i])
        );
    end

    // Read out the entry at the chosen position as a masked OR across cells.
    always_comb begin
        sel_key = '0;
        sel_pay = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_key = sel_key | (cell_key[i] & {KEY_BITS{hit_vec[i]}});
            sel_pay = sel_pay | (cell_pay[i] & {32{hit_vec[i]}});
        end
    end

    assign sel_key_wide = {32'b0, sel_key};

    // One search probe per cycle. The probe always lies below the live
    // count, so its low bits address the compare vectors directly.
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_sel = mid[IDX_W-1:0];

    // Update decision and result for the current request.
    always_comb begin
        res_found  = found_reg;
        res_idx    = idx_reg;
        res_key    = '0;
        res_pay    = '0;
        res_status = STAT_OK;
        act_op     = CELL_HOLD;
        fill_next  = fill_reg;
        unique case (mode_reg)
            MODE_SEARCH: begin
            end
            MODE_INSERT: begin
                if (found_reg) begin
                    act_op  = CELL_WRPAY;
                    res_pay = sel_pay;
                end else if (fill_reg == CNT_W'(CAPACITY)) begin
                    res_status = STAT_FULL;
                end else begin
                    act_op    = CELL_INS;
                    fill_next = fill_reg + 1'b1;
                end
            end
            MODE_DELETE, MODE_POP: begin
                // Pop arrives here with the last position marked as found.
                if (fill_reg == '0) begin
                    res_status = STAT_EMPTY;
                    res_found  = 1'b0;
                    res_idx    = '0;
                end else if (found_reg) begin
                    act_op    = CELL_DEL;
                    res_key   = sel_key_wide[31:0];
                    res_pay   = sel_pay;
                    fill_next = fill_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!act_fire) begin
            fill_next = fill_reg;
        end
    end

    assign idx_wide = {9'b0, res_idx};
    assign cnt_wide = {9'b0, fill_next};

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        cell_op      = CELL_HOLD;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // Every cell compares its entry with the new key now.
                    cell_op    = CELL_CMP;
                    mode_next  = s_data.mode;
                    key_next   = key_in;
                    pay_next   = s_data.payload;
                    lo_next    = '0;
                    hi_next    = fill_reg;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (mode_reg == MODE_POP) begin
                    idx_next   = fill_reg - 1'b1;
                    found_next = 1'b1;
                    state_next = ST_ACT;
                end else if (lo_reg >= hi_reg) begin
                    idx_next   = lo_reg;
                    found_next = 1'b0;
                    state_next = ST_ACT;
                end else if (mid == lo_reg) begin
                    // Last probe: decide between a match and the slot
                    // just before or after it.
                    found_next = 1'b0;
                    idx_next   = mid;
                    if (!key_lt_vec[mid_sel]) begin
                        if (!ent_lt_vec[mid_sel]) begin
                            found_next = 1'b1;
                        end else begin
                            idx_next = mid + 1'b1;
                        end
                    end
                    state_next = ST_ACT;
                end else if (key_lt_vec[mid_sel]) begin
                    hi_next = mid;
                end else begin
                    lo_next = mid;
                end
            end
            ST_ACT: begin
                if (act_fire) begin
                    cell_op                 = act_op;
                    m_valid_next            = 1'b1;
                    m_data_next.found       = res_found;
                    m_data_next.index       = idx_wide[8:0];
                    m_data_next.out_key     = res_key;
                    m_data_next.out_payload = res_pay;
                    m_data_next.status      = res_status;
                    m_data_next.entry_count = cnt_wide[8:0];
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            desc_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                desc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
